// ===== rtl/core/lpk_pkg.sv =====
// ---------------------------------------------------------------------------
// lpk_pkg: shared types and constants for the Laplace pairwise kernel
// Field widths, the format of the pass-through tag and the register indexes.
// ---------------------------------------------------------------------------
package lpk_pkg;

   localparam int BOX_W   = 10;
   localparam int COORD_W = 32;
   localparam int DIFF_W  = COORD_W + 1;        // |row - col| fits 33 bits
   localparam int SQ_W    = 2 * DIFF_W;         // 66-bit square
   localparam int SUM_W   = 66;                 // sum of three squares < 2^66
   localparam int ROOT_W  = 34;                 // floor sqrt of a 66-bit value
   localparam int REG_W   = 16;
   localparam int DEN_W   = ROOT_W + 1;         // root + regularizer
   localparam int NUM_W   = 37;                 // 2^36 + den/2
   localparam int DREM_W  = DEN_W + 1;
   localparam int RES_W   = 32;
   localparam int DIM_W   = 2;

   typedef struct packed {
      logic [BOX_W-1:0] row_box;
      logic [BOX_W-1:0] col_box;
      logic             last;
   } tag_type;

   typedef enum logic {
      REG_DIMENSIONS  = 1'b0,
      REG_REGULARIZER = 1'b1
   } reg_index_type;

   localparam logic [DIM_W-1:0] DIMS_RESET = 2'd3;
   localparam logic [REG_W-1:0] REGZ_RESET = 16'd66;

endpackage

// ===== rtl/core/laplace_pairwise_kernel_top.sv =====
// ---------------------------------------------------------------------------
// laplace_pairwise_kernel_top: regularized Laplace kernel, one pair per cycle unless stalled
// Computes 1/(|row - col| + regularizer) in unsigned Q12.20 from two Q16.16
// points, with the box tags and the last-pair flag passed through.
// ---------------------------------------------------------------------------
// Throughput is one transaction per cycle while the pipe is not stalled. The
// depth is set by the square root, which resolves one root bit per stage (34
// stages), and the restoring divider, which resolves one quotient bit per stage
// (37 stages). Stage order: axis differences, squares, sum, 34 root stages,
// denominator, 37 divide stages, output register.
// The whole pipe advances together whenever the output register is empty or
// being drained; a stall holds every stage in place.
module laplace_pairwise_kernel_top #(
   parameter int MAX_DIMS = 3
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [lpk_pkg::BOX_W-1:0]   req_row_box,
   input  logic [lpk_pkg::BOX_W-1:0]   req_col_box,
   input  logic signed [31:0]          req_row_x,
   input  logic signed [31:0]          req_row_y,
   input  logic signed [31:0]          req_row_z,
   input  logic signed [31:0]          req_col_x,
   input  logic signed [31:0]          req_col_y,
   input  logic signed [31:0]          req_col_z,
   input  logic                        req_last_pair,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [lpk_pkg::BOX_W-1:0]   rsp_out_row_box,
   output logic [lpk_pkg::BOX_W-1:0]   rsp_out_col_box,
   output logic [lpk_pkg::RES_W-1:0]   rsp_interaction,
   output logic                        rsp_saturated,
   output logic                        rsp_out_last,
   // register port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import lpk_pkg::*;

   localparam int SQRT_N = ROOT_W;              // root stages
   localparam int DIV_N  = NUM_W;               // divide stages
   localparam int P_LEN  = 3 + SQRT_N + 1 + DIV_N + 1;   // incl. output register

   // ---------------- configuration registers ----------------
   logic [DIM_W-1:0] dims_ff;
   logic [REG_W-1:0] regz_ff;
   logic             csr_wr;
   reg_index_type    csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = reg_index_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= DIMS_RESET;
         regz_ff <= REGZ_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_DIMENSIONS:  dims_ff <= csr_pwdata[DIM_W-1:0];
            REG_REGULARIZER: regz_ff <= csr_pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_DIMENSIONS:  csr_prdata = {{(32-DIM_W){1'b0}}, dims_ff};
         REG_REGULARIZER: csr_prdata = {{(32-REG_W){1'b0}}, regz_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   // Valid bits and tags ride a shift line alongside the data stages.
   logic    adv;
   logic    vld_ff [1:P_LEN];
   tag_type tag_ff [1:P_LEN];
   tag_type tag_in;

   assign adv       = ~vld_ff[P_LEN] | rsp_ready;
   assign req_ready = adv;

   assign tag_in.row_box = req_row_box;
   assign tag_in.col_box = req_col_box;
   assign tag_in.last    = req_last_pair;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= P_LEN; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[1] <= req_valid;
         for (int i = 2; i <= P_LEN; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[1] <= tag_in;
         for (int i = 2; i <= P_LEN; i++) tag_ff[i] <= tag_ff[i-1];
      end
   end

   // ---------------- stage 1: absolute axis differences ----------------
   logic signed [COORD_W-1:0] row_c [0:2];
   logic signed [COORD_W-1:0] col_c [0:2];
   logic [DIM_W-1:0]          ndim;
   logic [DIFF_W-1:0]         ad_in [0:MAX_DIMS-1];
   logic [DIFF_W-1:0]         ad_ff [0:MAX_DIMS-1];

   assign row_c[0] = req_row_x;
   assign row_c[1] = req_row_y;
   assign row_c[2] = req_row_z;
   assign col_c[0] = req_col_x;
   assign col_c[1] = req_col_y;
   assign col_c[2] = req_col_z;

   // zero dims means one axis; clamp to what was built
   always_comb begin
      ndim = (dims_ff == '0) ? DIM_W'(1) : dims_ff;
      if (ndim > DIM_W'(MAX_DIMS)) ndim = DIM_W'(MAX_DIMS);
   end

   always_comb begin
      for (int k = 0; k < MAX_DIMS; k++) begin
         logic signed [DIFF_W-1:0] d;
         d = DIFF_W'(row_c[k]) - DIFF_W'(col_c[k]);
         if (DIM_W'(k) >= ndim)
            ad_in[k] = '0;
         else
            ad_in[k] = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) for (int k = 0; k < MAX_DIMS; k++) ad_ff[k] <= ad_in[k];
   end

   // ---------------- stage 2: squares ----------------
   // a = h*2^32 + l with h one bit: a^2 = l^2 + h*l*2^33 + h*2^64
   logic [SQ_W-1:0] sq_in [0:MAX_DIMS-1];
   logic [SQ_W-1:0] sq_ff [0:MAX_DIMS-1];

   always_comb begin
      for (int k = 0; k < MAX_DIMS; k++) begin
         logic [31:0] lo;
         logic        hi;
         logic [63:0] p;
         lo = ad_ff[k][31:0];
         hi = ad_ff[k][32];
         p  = {32'b0, lo} * {32'b0, lo};
         sq_in[k] = {2'b0, p}
                  + (hi ? ({34'b0, lo} << 33) : '0)
                  + (hi ? (SQ_W'(1) << 64) : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) for (int k = 0; k < MAX_DIMS; k++) sq_ff[k] <= sq_in[k];
   end

   // ---------------- stage 3: sum of squares ----------------
   logic [SUM_W-1:0] sum_in;

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < MAX_DIMS; k++) sum_in = sum_in + sq_ff[k];
   end

   // ---------------- square root, one bit per stage ----------------
   // rem holds sum - root^2; stage k tests root bit SQRT_N-k.
   logic [SUM_W-1:0]  rem_ff  [0:SQRT_N];
   logic [ROOT_W-1:0] root_ff [0:SQRT_N];

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= sum_in;
         root_ff[0] <= '0;
      end
   end

   for (genvar k = 1; k <= SQRT_N; k++) begin : g_sqrt
      localparam int B = SQRT_N - k;
      logic [SUM_W+1:0] trial;
      logic             take;
      assign trial = ({{(SUM_W+2-ROOT_W){1'b0}}, root_ff[k-1]} << (B + 1))
                   + ((SUM_W+2)'(1) << (2 * B));
      assign take  = {2'b0, rem_ff[k-1]} >= trial;
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= take ? (rem_ff[k-1] - trial[SUM_W-1:0]) : rem_ff[k-1];
            root_ff[k] <= take ? (root_ff[k-1] | (ROOT_W'(1) << B)) : root_ff[k-1];
         end
      end
   end

   // ---------------- denominator ----------------
   logic [DEN_W-1:0] den_in;
   assign den_in = {1'b0, root_ff[SQRT_N]} + {{(DEN_W-REG_W){1'b0}}, regz_ff};

   // ---------------- restoring divide, one quotient bit per stage ----------
   // numerator 2^36 + den/2 gives round-to-nearest
   logic [DEN_W-1:0]  dden_ff [0:DIV_N];
   logic [NUM_W-1:0]  num_ff  [0:DIV_N];
   logic [DREM_W-1:0] drem_ff [0:DIV_N];
   logic [NUM_W-1:0]  quo_ff  [0:DIV_N];

   always_ff @(posedge clock) begin
      if (adv) begin
         dden_ff[0] <= den_in;
         num_ff[0]  <= (NUM_W'(1) << 36) + {{(NUM_W-DEN_W+1){1'b0}}, den_in[DEN_W-1:1]};
         drem_ff[0] <= '0;
         quo_ff[0]  <= '0;
      end
   end

   for (genvar j = 1; j <= DIV_N; j++) begin : g_div
      logic [DREM_W:0] sh;
      logic [DREM_W:0] df;
      logic            take;
      assign sh   = {drem_ff[j-1], num_ff[j-1][DIV_N-j]};
      assign take = sh >= {2'b0, dden_ff[j-1]};
      assign df   = sh - {2'b0, dden_ff[j-1]};
      always_ff @(posedge clock) begin
         if (adv) begin
            dden_ff[j] <= dden_ff[j-1];
            num_ff[j]  <= num_ff[j-1];
            drem_ff[j] <= take ? df[DREM_W-1:0] : sh[DREM_W-1:0];
            quo_ff[j]  <= {quo_ff[j-1][NUM_W-2:0], take};
         end
      end
   end

   // ---------------- output register ----------------
   // zero denominator yields an all-ones quotient, so it saturates too
   logic [RES_W-1:0] res_ff;
   logic             sat_ff;
   logic             ovf;

   assign ovf = (quo_ff[DIV_N][NUM_W-1:RES_W] != '0) || (dden_ff[DIV_N] == '0);

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= ovf ? '1 : quo_ff[DIV_N][RES_W-1:0];
         sat_ff <= ovf;
      end
   end

   assign rsp_valid       = vld_ff[P_LEN];
   assign rsp_out_row_box = tag_ff[P_LEN].row_box;
   assign rsp_out_col_box = tag_ff[P_LEN].col_box;
   assign rsp_out_last    = tag_ff[P_LEN].last;
   assign rsp_interaction = res_ff;
   assign rsp_saturated   = sat_ff;

endmodule

// ===== test/laplace_pairwise_kernel_top_tb.sv =====
// ---------------------------------------------------------------------------
// laplace_pairwise_kernel_top_tb: self-checking bench for the Laplace kernel
// Streams point pairs through the pipe under random back-pressure on both
// channels, predicts 1/(|row - col| + regularizer) per pair and checks every
// response in order, over several dimension and regularizer settings.
// ---------------------------------------------------------------------------
module laplace_pairwise_kernel_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lpk_pkg::*;

   localparam int MAX_DIMS   = 3;     // axes built into the DUT
   localparam int PIPE_DRAIN = 100;   // drain wait, longer than the pipe latency
   localparam int IDLE_LIMIT = 5000;  // cycles without any transaction
   localparam int HOLD_OFF   = 400;   // long receiver stall, cycles

   typedef struct {
      logic [BOX_W-1:0]   row_box, col_box;
      logic [COORD_W-1:0] row_x, row_y, row_z, col_x, col_y, col_z;
      logic               last;
   } pair_type;

   typedef struct {
      logic [BOX_W-1:0] row_box, col_box;
      logic [RES_W-1:0] interaction;
      logic             saturated, last;
   } kernel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [BOX_W-1:0]   req_row_box = '0, req_col_box = '0;
   logic signed [31:0] req_row_x = '0, req_row_y = '0, req_row_z = '0;
   logic signed [31:0] req_col_x = '0, req_col_y = '0, req_col_z = '0;
   logic               req_last_pair = 1'b0;

   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [BOX_W-1:0]   rsp_out_row_box, rsp_out_col_box;
   logic [RES_W-1:0]   rsp_interaction;
   logic               rsp_saturated, rsp_out_last;

   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // bench copy of the register file
   logic [DIM_W-1:0] cfg_dims = DIMS_RESET;
   logic [REG_W-1:0] cfg_regz = REGZ_RESET;

   pair_type   pending_pairs[$];   // waiting to be offered
   kernel_type kernel_values[$];   // predicted, waiting for a response
   pair_type   offered;
   int         gap_left = 0;
   int         stall_left = 0;
   int         rsp_count = 0;
   bit         held_off = 1'b0;
   int         failures = 0;
   int         idle_cycles = 0;

   laplace_pairwise_kernel_top #(.MAX_DIMS(MAX_DIMS)) i_dut (.*);

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Kernel prediction: exact squared distance, floor root, rounded quotient.
   // ------------------------------------------------------------------------
   function automatic kernel_type kernel_of(pair_type p, logic [DIM_W-1:0] dims,
                                            logic [REG_W-1:0] regz);
      kernel_type k;
      logic signed [COORD_W:0] d;
      logic [COORD_W:0]   ad;
      logic [67:0]        sum, sq;
      logic [ROOT_W-1:0]  root, cand;
      logic [63:0]        den, q;
      logic [COORD_W-1:0] rc[3], cc[3];
      int n;
      rc = '{p.row_x, p.row_y, p.row_z};
      cc = '{p.col_x, p.col_y, p.col_z};
      n = (dims == 0) ? 1 : ((dims > MAX_DIMS) ? MAX_DIMS : dims);
      sum = '0;
      for (int a = 0; a < n; a++) begin
         d = $signed({rc[a][31], rc[a]}) - $signed({cc[a][31], cc[a]});
         ad = d[COORD_W] ? -d : d;
         sq = 68'(ad) * 68'(ad);
         sum += sq;
      end
      root = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         cand = root | (34'd1 << b);
         if (68'(cand) * 68'(cand) <= sum) root = cand;
      end
      den = 64'(root) + 64'(regz);
      k.saturated = 1'b0;
      if (den == 0) begin
         q = 64'hFFFF_FFFF;
         k.saturated = 1'b1;
      end else begin
         q = ((64'd1 << 36) + (den >> 1)) / den;
         if (q > 64'hFFFF_FFFF) begin
            q = 64'hFFFF_FFFF;
            k.saturated = 1'b1;
         end
      end
      k.interaction = q[31:0];
      k.row_box = p.row_box;
      k.col_box = p.col_box;
      k.last = p.last;
      return k;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h (t=%0t)", what, got, want, $realtime);
      failures++;
   endtask

   // no gap mostly, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ------------------------------------------------------------------------
   // Driver: offers pending pairs, predicts each one as it is accepted.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      pair_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && req_ready)
            kernel_values = {kernel_values, kernel_of(offered, cfg_dims, cfg_regz)};
         // a held transaction stays put until it is accepted
         if (!(req_valid && !req_ready)) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
               nxt = pending_pairs.pop_front();
               offered <= nxt;
               req_row_box <= nxt.row_box;
               req_col_box <= nxt.col_box;
               req_row_x <= nxt.row_x;
               req_row_y <= nxt.row_y;
               req_row_z <= nxt.row_z;
               req_col_x <= nxt.col_x;
               req_col_y <= nxt.col_y;
               req_col_z <= nxt.col_z;
               req_last_pair <= nxt.last;
               req_valid <= 1'b1;
               gap_left <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each response against the oldest prediction and
   // throttles rsp_ready; one long hold-off lets the pipe fill and stall.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      kernel_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (kernel_values.size() == 0) begin
               report_mismatch("unexpected response", 64'd1, 64'd0);
            end else begin
               want = kernel_values.pop_front();
               if (rsp_out_row_box !== want.row_box)
                  report_mismatch("row_box", rsp_out_row_box, want.row_box);
               if (rsp_out_col_box !== want.col_box)
                  report_mismatch("col_box", rsp_out_col_box, want.col_box);
               if (rsp_interaction !== want.interaction)
                  report_mismatch("interaction", rsp_interaction, want.interaction);
               if (rsp_saturated !== want.saturated)
                  report_mismatch("saturated", rsp_saturated, want.saturated);
               if (rsp_out_last !== want.last)
                  report_mismatch("last", rsp_out_last, want.last);
            end
         end
         if (!held_off && rsp_count >= 150) begin
            held_off <= 1'b1;
            stall_left <= HOLD_OFF;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            stall_left <= pick_gap();
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: no transaction on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic wait_drained();
      while (pending_pairs.size() > 0 || req_valid || kernel_values.size() > 0)
         @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(idx) << 2;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);  // register written at this edge
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_DIMENSIONS) cfg_dims = value[DIM_W-1:0];
      else cfg_regz = value[REG_W-1:0];
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 65535) - 32768;
         default: return $urandom;
      endcase
   endfunction

   // random pair: near neighbors and far-apart pairs, some coincident
   function automatic pair_type rand_pair();
      pair_type p;
      int r;
      p.row_box = BOX_W'($urandom);
      p.col_box = BOX_W'($urandom);
      p.last = ($urandom_range(7) == 0);
      p.row_x = rand_coord();
      p.row_y = rand_coord();
      p.row_z = rand_coord();
      r = $urandom_range(9);
      if (r < 2) begin
         p.col_x = p.row_x; p.col_y = p.row_y; p.col_z = p.row_z;
      end else if (r < 6) begin
         p.col_x = p.row_x + $urandom_range(0, 15) - 7;
         p.col_y = p.row_y + $urandom_range(0, 1023) - 512;
         p.col_z = p.row_z + $urandom_range(0, 262143) - 131072;
      end else begin
         p.col_x = rand_coord(); p.col_y = rand_coord(); p.col_z = rand_coord();
      end
      return p;
   endfunction

   function automatic pair_type make_pair(logic [9:0] rb, logic [9:0] cb,
                                          logic [31:0] r, logic [31:0] c, logic l);
      pair_type p;
      p = '{rb, cb, r, r, r, c, c, c, l};
      return p;
   endfunction

   task automatic add_pair(pair_type p);
      pending_pairs = {pending_pairs, p};
   endtask

   task automatic directed_pairs();
      pair_type p;
      add_pair(make_pair(10'd0, 10'd1023, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
      add_pair(make_pair(10'd1023, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
      add_pair(make_pair(10'h155, 10'h2AA, 32'h0, 32'h0, 1'b0));
      add_pair(make_pair(10'h2AA, 10'h155, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
      add_pair(make_pair(10'd5, 10'd6, 32'h0001_0000, 32'h0, 1'b0));
      add_pair(make_pair(10'd7, 10'd8, 32'h0, 32'h0000_0001, 1'b0));
      // only one axis differs, so masked axes show up
      p = make_pair(10'd9, 10'd10, 32'h0, 32'h0, 1'b0);
      p.col_z = 32'h7FFF_FFFF;
      add_pair(p);
      p = make_pair(10'd11, 10'd12, 32'h0, 32'h0, 1'b1);
      p.row_y = 32'h8000_0000;
      add_pair(p);
      p = make_pair(10'd13, 10'd14, 32'h0, 32'h0, 1'b0);
      p.row_x = 32'h0000_0003;
      add_pair(p);
   endtask

   initial begin
      logic [DIM_W-1:0] dims_set[5] = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd2};
      logic [REG_W-1:0] regz_set[5] = '{16'd1, 16'd65535, 16'd0, 16'd1000, 16'd66};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings first
      directed_pairs();
      for (int i = 0; i < 120; i++) add_pair(rand_pair());

      for (int ph = 0; ph < 5; ph++) begin
         wait_drained();
         csr_write(REG_DIMENSIONS, 32'(dims_set[ph]));
         csr_write(REG_REGULARIZER, 32'(regz_set[ph]));
         directed_pairs();
         for (int i = 0; i < 130; i++) add_pair(rand_pair());
      end

      wait_drained();
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
